FILE: rtl/n_queens_backtrack_solver_assert.svh
// Assertion macros used by the checker of the solver.
`ifndef N_QUEENS_BACKTRACK_SOLVER_ASSERT_SVH
`define N_QUEENS_BACKTRACK_SOLVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NQB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("solver check failed");

// The consequent must hold in the cycle after the antecedent.
`define NQB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("solver check failed");

`endif

FILE: rtl/nqb_pkg.sv
package nqb_pkg;

  localparam int MAX_BOARD   = 8;
  localparam int MAX_RESULTS = 64;
  localparam int ROW_W       = 3;
  localparam int CAND_W      = 4;
  localparam int PLACE_W     = 24;
  localparam int NUM_W       = 7;

  typedef enum logic [3:0] {
    S_IDLE   = 4'd0,
    S_START  = 4'd1,
    S_TRY    = 4'd2,
    S_COLCHK = 4'd3,
    S_PLACE  = 4'd4,
    S_SOLN   = 4'd5,
    S_BCHK   = 4'd6,
    S_END    = 4'd7,
    S_FINAL  = 4'd8,
    S_MARK   = 4'd9,
    S_EMIT   = 4'd10,
    S_AFTER  = 4'd11
  } step_t;

  typedef enum logic [2:0] {
    C_IN_VALID,
    C_OFF_BOARD,
    C_ROW_START,
    C_COL_DONE,
    C_FREE,
    C_HELD,
    C_OUT_FREE,
    C_LIMIT
  } cond_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_LOAD,
    A_PLACE,
    A_NEXT_COL,
    A_BACK,
    A_HOLD,
    A_EMIT,
    A_FINAL,
    A_MARKER
  } action_t;

  typedef struct packed {
    cond_t   cond;
    action_t act_t;
    action_t act_f;
    step_t   next_t;
    step_t   next_f;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic off_board;
    logic row_start;
    logic col_done;
    logic free;
    logic held;
    logic out_free;
    logic limit;
  } status_t;

  function automatic ctrl_word_t ucode(input step_t pc);
    ctrl_word_t w;
    case (pc)
      S_IDLE:   w = '{C_IN_VALID,  A_LOAD,   A_NONE,     S_START, S_IDLE};
      S_START:  w = '{C_OFF_BOARD, A_NONE,   A_NONE,     S_END,   S_TRY};
      S_TRY:    w = '{C_ROW_START, A_NONE,   A_NONE,     S_SOLN,  S_COLCHK};
      S_COLCHK: w = '{C_COL_DONE,  A_BACK,   A_NONE,     S_BCHK,  S_PLACE};
      S_PLACE:  w = '{C_FREE,      A_PLACE,  A_NEXT_COL, S_TRY,   S_TRY};
      S_SOLN:   w = '{C_HELD,      A_NONE,   A_HOLD,     S_EMIT,  S_AFTER};
      S_EMIT:   w = '{C_OUT_FREE,  A_EMIT,   A_NONE,     S_AFTER, S_EMIT};
      S_AFTER:  w = '{C_LIMIT,     A_NONE,   A_BACK,     S_END,   S_BCHK};
      S_BCHK:   w = '{C_ROW_START, A_NONE,   A_NONE,     S_END,   S_COLCHK};
      S_END:    w = '{C_HELD,      A_NONE,   A_NONE,     S_FINAL, S_MARK};
      S_FINAL:  w = '{C_OUT_FREE,  A_FINAL,  A_NONE,     S_IDLE,  S_FINAL};
      S_MARK:   w = '{C_OUT_FREE,  A_MARKER, A_NONE,     S_IDLE,  S_MARK};
      default:  w = '{C_IN_VALID,  A_NONE,   A_NONE,     S_IDLE,  S_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/nqb_sequencer.sv
module nqb_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  nqb_pkg::status_t  status,
  output nqb_pkg::action_t  action,
  output logic              idle
);

  nqb_pkg::step_t      pc;
  nqb_pkg::step_t      pc_next;
  nqb_pkg::ctrl_word_t word;
  logic                hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= nqb_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    word = nqb_pkg::ucode(pc);
    case (word.cond)
      nqb_pkg::C_IN_VALID:  hit = status.in_valid;
      nqb_pkg::C_OFF_BOARD: hit = status.off_board;
      nqb_pkg::C_ROW_START: hit = status.row_start;
      nqb_pkg::C_COL_DONE:  hit = status.col_done;
      nqb_pkg::C_FREE:      hit = status.free;
      nqb_pkg::C_HELD:      hit = status.held;
      nqb_pkg::C_OUT_FREE:  hit = status.out_free;
      nqb_pkg::C_LIMIT:     hit = status.limit;
      default:              hit = 1'b0;
    endcase
    action  = hit ? word.act_t : word.act_f;
    pc_next = hit ? word.next_t : word.next_f;
    idle    = (pc == nqb_pkg::S_IDLE);
  end

endmodule

FILE: rtl/nqb_datapath.sv
module nqb_datapath #(
  parameter int BOARD_SIZE = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  nqb_pkg::action_t            action,
  input  logic                        in_valid,
  input  logic [nqb_pkg::ROW_W-1:0]   start_row,
  input  logic [nqb_pkg::ROW_W-1:0]   start_col,
  input  logic                        out_stall,
  output nqb_pkg::status_t            status,
  output logic                        out_valid,
  output logic [nqb_pkg::PLACE_W-1:0] placement,
  output logic [nqb_pkg::NUM_W-1:0]   solution_number,
  output logic                        found,
  output logic                        last
);

  localparam int RW = nqb_pkg::ROW_W;
  localparam int CW = nqb_pkg::CAND_W;

  logic [RW-1:0]              cols [nqb_pkg::MAX_BOARD];
  logic                       occ  [nqb_pkg::MAX_BOARD];
  logic [RW-1:0]              row;
  logic [CW-1:0]              col;
  logic [RW-1:0]              sr;
  logic                       off_board;
  logic [nqb_pkg::NUM_W-1:0]  count;
  logic [nqb_pkg::PLACE_W-1:0] held_place;

  logic [RW-1:0]               row_inc;
  logic [RW-1:0]               row_dec;
  logic [RW-1:0]               start_inc;
  logic                        start_off;
  logic                        conflict;
  logic                        out_free;
  logic [nqb_pkg::PLACE_W-1:0] cur_place;

  always_comb begin
    logic [RW-1:0] dc;
    logic [RW-1:0] dr;
    row_inc   = (row == RW'(BOARD_SIZE - 1)) ? '0 : row + RW'(1);
    row_dec   = (row == '0) ? RW'(BOARD_SIZE - 1) : row - RW'(1);
    start_inc = (start_row == RW'(BOARD_SIZE - 1)) ? '0 : start_row + RW'(1);
    start_off = ({1'b0, start_row} >= CW'(BOARD_SIZE)) ||
                ({1'b0, start_col} >= CW'(BOARD_SIZE));
    conflict  = 1'b0;
    cur_place = '0;
    for (int i = 0; i < BOARD_SIZE; i++) begin
      dc = (cols[i] >= col[RW-1:0]) ? cols[i] - col[RW-1:0] : col[RW-1:0] - cols[i];
      dr = (RW'(i) >= row) ? RW'(i) - row : row - RW'(i);
      if (occ[i]) begin
        if ((cols[i] == col[RW-1:0]) || (dc == dr)) begin
          conflict = 1'b1;
        end
        cur_place[RW*i +: RW] = cols[i];
      end
    end
    out_free = !out_valid || !out_stall;

    status.in_valid  = in_valid;
    status.off_board = off_board;
    status.row_start = (row == sr);
    status.col_done  = (col == CW'(BOARD_SIZE));
    status.free      = !conflict;
    status.held      = (count != '0);
    status.out_free  = out_free;
    status.limit     = (count == nqb_pkg::NUM_W'(nqb_pkg::MAX_RESULTS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < nqb_pkg::MAX_BOARD; i++) begin
        occ[i] <= 1'b0;
      end
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (action inside {nqb_pkg::A_EMIT, nqb_pkg::A_FINAL, nqb_pkg::A_MARKER}) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
      case (action)
        nqb_pkg::A_LOAD: begin
          for (int i = 0; i < nqb_pkg::MAX_BOARD; i++) begin
            occ[i] <= !start_off && (RW'(i) == start_row);
          end
          if (!start_off) begin
            cols[start_row] <= start_col;
          end
          off_board <= start_off;
          sr        <= start_row;
          row       <= start_inc;
          col       <= '0;
          count     <= '0;
        end
        nqb_pkg::A_PLACE: begin
          cols[row] <= col[RW-1:0];
          occ[row]  <= 1'b1;
          row       <= row_inc;
          col       <= '0;
        end
        nqb_pkg::A_NEXT_COL: begin
          col <= col + CW'(1);
        end
        nqb_pkg::A_BACK: begin
          row <= row_dec;
          col <= {1'b0, cols[row_dec]} + CW'(1);
          if (row_dec != sr) begin
            occ[row_dec] <= 1'b0;
          end
        end
        nqb_pkg::A_HOLD: begin
          held_place <= cur_place;
          count      <= count + nqb_pkg::NUM_W'(1);
        end
        nqb_pkg::A_EMIT: begin
          placement       <= held_place;
          solution_number <= count;
          found           <= 1'b1;
          last            <= 1'b0;
          held_place      <= cur_place;
          count           <= count + nqb_pkg::NUM_W'(1);
        end
        nqb_pkg::A_FINAL: begin
          placement       <= held_place;
          solution_number <= count;
          found           <= 1'b1;
          last            <= 1'b1;
        end
        nqb_pkg::A_MARKER: begin
          placement       <= '0;
          solution_number <= '0;
          found           <= 1'b0;
          last            <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/n_queens_backtrack_solver.sv
// N-queens solver with a fixed first queen.
// The input channel takes one word per search: start_row and start_col of the
// first queen. in_stall stays high from the accepting edge until the last
// result of that search has been loaded into the output register.
// The output channel gives one word per solution, in depth-first search order,
// with placement packed three bits per row and a running solution_number.
// The final word carries last. A search with no solution, or a start square
// off the board, gives one word with found low, zeros and last high.
// A microcoded sequencer steps a board datapath; each tried square passes
// through S_TRY, S_COLCHK and S_PLACE, and each backtrack through S_COLCHK
// and S_BCHK.
// The first result appears once the second solution has been found or the
// search has ended, since a solution is held back until it is known whether
// it is the last one.
// When out_stall is high the output word holds and the search pauses at its
// next result until the register frees. Reset returns the sequencer to idle
// and drops any pending output word.
module n_queens_backtrack_solver #(
  parameter int BOARD_SIZE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  start_row,
  input  logic [2:0]  start_col,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] placement,
  output logic [6:0]  solution_number,
  output logic        found,
  output logic        last
);

  nqb_pkg::status_t status;
  nqb_pkg::action_t action;
  logic             idle;

  assign in_stall = !idle;

  nqb_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .action (action),
    .idle   (idle)
  );

  nqb_datapath #(
    .BOARD_SIZE (BOARD_SIZE)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .action          (action),
    .in_valid        (in_valid),
    .start_row       (start_row),
    .start_col       (start_col),
    .out_stall       (out_stall),
    .status          (status),
    .out_valid       (out_valid),
    .placement       (placement),
    .solution_number (solution_number),
    .found           (found),
    .last            (last)
  );

endmodule

FILE: rtl/nqb_checker.sv
`include "n_queens_backtrack_solver_assert.svh"

module nqb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] placement,
  input logic [6:0]  solution_number,
  input logic        found,
  input logic        last
);

  logic [32:0] out_word;

  assign out_word = {placement, solution_number, found, last};

  `NQB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
  `NQB_ASSERT_SAME(a_marker, out_valid && !found, last && (out_word[32:2] == '0))
  `NQB_ASSERT_SAME(a_busy_mid, out_valid && !last, in_stall)
  `NQB_ASSERT_NEXT(a_busy_start, in_valid && !in_stall, in_stall)

endmodule

bind n_queens_backtrack_solver nqb_checker u_nqb_checker (.*);

FILE: test/n_queens_backtrack_solver_checker.sv
module n_queens_backtrack_solver_checker #(
  parameter int BOARD_SIZE = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [nqb_pkg::ROW_W-1:0]   start_row,
  input  logic [nqb_pkg::ROW_W-1:0]   start_col,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [nqb_pkg::PLACE_W-1:0] placement,
  input  logic [nqb_pkg::NUM_W-1:0]   solution_number,
  input  logic                        found,
  input  logic                        last,
  output int                          mismatches,
  output int                          outstanding
);

  localparam int ROW_W       = nqb_pkg::ROW_W;
  localparam int PLACE_W     = nqb_pkg::PLACE_W;
  localparam int NUM_W       = nqb_pkg::NUM_W;
  localparam int MAX_BOARD   = nqb_pkg::MAX_BOARD;
  localparam int MAX_RESULTS = nqb_pkg::MAX_RESULTS;

  typedef struct packed {
    logic [PLACE_W-1:0] placement;
    logic [NUM_W-1:0]   number;
    logic               found;
    logic               last;
  } solution_t;

  solution_t solutions_due[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Depth-first search over the rows after the fixed queen, in circular order,
  // queuing every complete board up to MAX_RESULTS and flagging the final word of the search.
  task automatic enumerate_placements(input logic [ROW_W-1:0] sr,
                                      input logic [ROW_W-1:0] sc);
    logic [ROW_W-1:0]   col_of[MAX_BOARD];
    logic               taken[MAX_BOARD];
    int                 row_at[MAX_BOARD];
    int                 next_col[MAX_BOARD];
    int                 depth;
    int                 row;
    int                 c;
    int                 i;
    int                 dc;
    int                 dr;
    int                 n_found;
    bit                 clear;
    logic [PLACE_W-1:0] cols_word;
    solution_t          s;
    n_found = 0;
    for (i = 0; i < MAX_BOARD; i++) begin
      col_of[i]   = '0;
      taken[i]    = 1'b0;
      row_at[i]   = 0;
      next_col[i] = 0;
    end
    if (sr < BOARD_SIZE && sc < BOARD_SIZE) begin
      col_of[sr] = sc;
      taken[sr]  = 1'b1;
      for (i = 0; i < BOARD_SIZE - 1; i++)
        row_at[i] = (int'(sr) + 1 + i) % BOARD_SIZE;
      depth = 0;
      while (depth >= 0 && n_found < MAX_RESULTS) begin
        if (depth == BOARD_SIZE - 1 || next_col[depth] >= BOARD_SIZE) begin
          if (depth == BOARD_SIZE - 1) begin
            cols_word = '0;
            for (i = 0; i < MAX_BOARD; i++)
              if (taken[i])
                cols_word = cols_word | (PLACE_W'(col_of[i]) << (3 * i));
            n_found++;
            s = '{cols_word, NUM_W'(n_found), 1'b1, 1'b0};
            solutions_due.push_back(s);
          end
          depth--;
          if (depth >= 0) begin
            taken[row_at[depth]]  = 1'b0;
            col_of[row_at[depth]] = '0;
            next_col[depth]++;
          end
        end else begin
          row   = row_at[depth];
          c     = next_col[depth];
          clear = 1'b1;
          for (i = 0; i < BOARD_SIZE; i++) begin
            dc = int'(col_of[i]) - c;
            dr = i - row;
            if (dc < 0) dc = -dc;
            if (dr < 0) dr = -dr;
            if (taken[i] && (dc == 0 || dc == dr))
              clear = 1'b0;
          end
          if (clear) begin
            col_of[row] = ROW_W'(c);
            taken[row]  = 1'b1;
            depth++;
            next_col[depth] = 0;
          end else begin
            next_col[depth]++;
          end
        end
      end
    end
    if (n_found == 0) begin
      s = '{'0, '0, 1'b0, 1'b1};
    end else begin
      s = solutions_due.pop_back();
      s.last = 1'b1;
    end
    solutions_due.push_back(s);
  endtask

  always @(posedge clk) begin
    solution_t want;
    if (!rst) begin
      if (in_valid && !in_stall)
        enumerate_placements(start_row, start_col);
      if (out_valid && !out_stall) begin
        if (solutions_due.size() == 0) begin
          $display("%0t: word with nothing expected: placement=%h number=%0d found=%b last=%b",
                   $time, placement, solution_number, found, last);
          mismatches++;
        end else begin
          want = solutions_due.pop_front();
          if (placement !== want.placement) begin
            $display("%0t: placement expected %h, got %h", $time, want.placement, placement);
            mismatches++;
          end
          if (solution_number !== want.number) begin
            $display("%0t: solution_number expected %0d, got %0d",
                     $time, want.number, solution_number);
            mismatches++;
          end
          if (found !== want.found) begin
            $display("%0t: found expected %b, got %b", $time, want.found, found);
            mismatches++;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %b, got %b", $time, want.last, last);
            mismatches++;
          end
        end
      end
      outstanding = solutions_due.size();
    end
  end

endmodule

FILE: test/n_queens_backtrack_solver_test.sv
module n_queens_backtrack_solver_test;

  localparam int BOARD_SIZE = 8;
  localparam int LONG_HOLD  = 3000;
  localparam int IDLE_LIMIT = 60000;
  localparam int RANDOM_SQUARES = 94;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  start_row = 3'd0;
  logic [2:0]  start_col = 3'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] placement;
  logic [6:0]  solution_number;
  logic        found;
  logic        last;
  int          mismatches;
  int          outstanding;

  n_queens_backtrack_solver #(
    .BOARD_SIZE(BOARD_SIZE)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .start_row(start_row),
    .start_col(start_col),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .placement(placement),
    .solution_number(solution_number),
    .found(found),
    .last(last)
  );

  n_queens_backtrack_solver_checker #(
    .BOARD_SIZE(BOARD_SIZE)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .start_row(start_row),
    .start_col(start_col),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .placement(placement),
    .solution_number(solution_number),
    .found(found),
    .last(last),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 16);
    end else begin
      return $urandom_range(40, 250);
    end
  endfunction

  task automatic send_square(input logic [2:0] r, input logic [2:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    start_row <= r;
    start_col <= c;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (outstanding == 0);
  endtask

  initial begin : receiver
    int bursts;
    int len;
    bursts = 0;
    forever begin
      @(negedge clk);
      bursts++;
      if (bursts == 40 || bursts == 400) begin
        len = LONG_HOLD;
      end else begin
        len = pick_gap();
      end
      if (len > 0) begin
        out_stall <= 1'b1;
        repeat (len) @(negedge clk);
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 19) == 0) begin
        repeat (300) @(negedge clk);
      end else begin
        repeat ($urandom_range(0, 20)) @(negedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int i;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Both diagonals: every corner, the center squares and every row and column.
    for (i = 0; i < BOARD_SIZE; i++) begin
      send_square(i[2:0], i[2:0]);
      send_square(i[2:0], 3'(BOARD_SIZE - 1 - i));
    end
    wait_for_results();
    for (i = 0; i < RANDOM_SQUARES; i++)
      send_square(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    wait_for_results();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: n_queens_backtrack_solver.f
+incdir+rtl
rtl/nqb_pkg.sv
rtl/nqb_sequencer.sv
rtl/nqb_datapath.sv
rtl/n_queens_backtrack_solver.sv
rtl/nqb_checker.sv
test/n_queens_backtrack_solver_checker.sv
test/n_queens_backtrack_solver_test.sv
